FILE: rtl/core/idpa_pkg.sv
package idpa_pkg;

	localparam int CNT_W     = 11;
	localparam int TGT_W     = 11;
	localparam int MODE_W    = 3;
	localparam int ID_OUT_W  = 10;
	localparam int GRP_SIZE  = 32;
	localparam int GRP_W     = 5;
	localparam int IN_DATA_W  = 16;
	localparam int OUT_DATA_W = 40;

	localparam logic [CNT_W-1:0] COUNT_MAX   = 11'h7FF;
	localparam logic [CNT_W-1:0] MAX_IDS_RST = 11'd1024;

	localparam logic [MODE_W-1:0] MODE_CREATE  = 3'd0;
	localparam logic [MODE_W-1:0] MODE_DEL_ONE = 3'd1;
	localparam logic [MODE_W-1:0] MODE_DEL_ALL = 3'd2;
	localparam logic [MODE_W-1:0] MODE_QUERY   = 3'd3;
	localparam logic [MODE_W-1:0] MODE_FINISH  = 3'd4;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_INVALID = 2'd1;
	localparam logic [1:0] STS_FULL    = 2'd2;

	localparam logic [1:0] ID_IN_USE   = 2'd0;
	localparam logic [1:0] ID_DELETING = 2'd1;
	localparam logic [1:0] ID_UNUSED   = 2'd2;
	localparam logic [1:0] ID_INVALID  = 2'd3;

	typedef enum logic [2:0] {
		S_IDLE,
		S_PRE1,
		S_PRE2,
		S_APPLY,
		S_POST1,
		S_POST2,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load_in;
		logic apply;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic out_busy;
	} sts_t;

endpackage

FILE: rtl/core/id_pool_allocator_with_deferred_delete.sv
// Pool id allocator with deferred deletion. Each command word (mode in s_axis_tuser,
// target id in s_axis_tdata) gives exactly one result word: status, granted id, state of
// the target, lowest pending id, an all-marked flag and the live count after the command.
// Both bitmaps sit in flops; find-first-free and find-first-pending run through a
// two-level registered priority tree (groups of 32 ids, then across groups), which is
// walked once before the update and once after it. A command is accepted only in the idle
// state, so a new command is taken only after the result of the last one has been
// registered; commands never overlap. The result waits in an output register, so a stalled
// result only holds the next command once that one has finished. max_ids may be rewritten
// while no command is in flight; id 0 is in use from reset.
module id_pool_allocator_with_deferred_delete #(
	parameter int NUM_IDS = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // target_id [10:0]
	input  logic [2:0]  s_axis_tuser,   // mode [2:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// status [1:0], granted_id [11:2], id_state [13:12], pending_any [14],
	// first_pending [24:15], all_marked [25], live_count [36:26]
	output logic [39:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data        // max_ids
);

	idpa_pkg::cmd_t cmd;
	idpa_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	idpa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	idpa_dp #(
		.NUM_IDS (NUM_IDS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.mode_in   (s_axis_tuser),
		.target_in (s_axis_tdata[10:0]),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.m_tready  (m_axis_tready),
		.m_tvalid  (m_axis_tvalid),
		.m_tdata   (m_axis_tdata)
	);

endmodule

FILE: rtl/core/idpa_ctrl.sv
module idpa_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  idpa_pkg::sts_t   sts,
	output idpa_pkg::cmd_t   cmd
);

	idpa_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= idpa_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			idpa_pkg::S_IDLE: begin
				if (s_tvalid) begin
					state_d = idpa_pkg::S_PRE1;
				end
			end
			idpa_pkg::S_PRE1:  state_d = idpa_pkg::S_PRE2;
			idpa_pkg::S_PRE2:  state_d = idpa_pkg::S_APPLY;
			idpa_pkg::S_APPLY: state_d = idpa_pkg::S_POST1;
			idpa_pkg::S_POST1: state_d = idpa_pkg::S_POST2;
			idpa_pkg::S_POST2: state_d = idpa_pkg::S_RESP;
			idpa_pkg::S_RESP: begin
				if (!sts.out_busy) begin
					state_d = idpa_pkg::S_IDLE;
				end
			end
			default: state_d = idpa_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		s_tready     = 1'b0;
		cmd.load_in  = 1'b0;
		cmd.apply    = 1'b0;
		cmd.load_out = 1'b0;
		case (state_q)
			idpa_pkg::S_IDLE: begin
				s_tready    = 1'b1;
				cmd.load_in = s_tvalid;
			end
			idpa_pkg::S_APPLY: cmd.apply = 1'b1;
			idpa_pkg::S_RESP:  cmd.load_out = !sts.out_busy;
			default: begin
			end
		endcase
	end

endmodule

FILE: rtl/core/idpa_dp.sv
module idpa_dp #(
	parameter int NUM_IDS = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  idpa_pkg::cmd_t                     cmd,
	output idpa_pkg::sts_t                     sts,
	input  logic [idpa_pkg::MODE_W-1:0]        mode_in,
	input  logic [idpa_pkg::TGT_W-1:0]         target_in,
	input  logic                               cfg_we,
	input  logic [idpa_pkg::CNT_W-1:0]         cfg_data,
	input  logic                               m_tready,
	output logic                               m_tvalid,
	output logic [idpa_pkg::OUT_DATA_W-1:0]    m_tdata
);

	localparam int IDXW = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
	localparam int G    = idpa_pkg::GRP_SIZE;
	localparam int GIW  = idpa_pkg::GRP_W;
	localparam int NG   = (NUM_IDS + G - 1) / G;
	localparam int PADN = NG * G;
	localparam int CW   = idpa_pkg::CNT_W;

	logic [NUM_IDS-1:0]          in_use_q, del_q;
	logic [CW-1:0]               count_q, max_ids_q;
	logic [idpa_pkg::MODE_W-1:0] mode_q;
	logic [idpa_pkg::TGT_W-1:0]  target_q;
	logic [1:0]                  status_q;
	logic [idpa_pkg::ID_OUT_W-1:0] granted_q;

	// per-id candidate vectors, padded to whole groups
	logic [PADN-1:0] fr_vec, pd_vec, eq_vec;

	logic [NG-1:0]  fr_any_c, pd_any_c, ok_c;
	logic [GIW-1:0] fr_idx_c [NG];
	logic [GIW-1:0] pd_idx_c [NG];
	logic [NG-1:0]  fr_any_s1, pd_any_s1, ok_s1;
	logic [GIW-1:0] fr_idx_s1 [NG];
	logic [GIW-1:0] pd_idx_s1 [NG];

	logic            fr_found_c, pd_any_c2, all_c;
	logic [IDXW-1:0] fr_id_c, pd_id_c;
	logic            fr_found_s2, pd_any_s2, all_s2;
	logic [IDXW-1:0] fr_id_s2, pd_id_s2;

	logic            t_valid, t_use, t_del, t_pend, t_live;
	logic [IDXW-1:0] tidx;
	logic [1:0]      id_st_c;
	logic            create_ok;
	logic [1:0]      status_c;
	logic [idpa_pkg::ID_OUT_W-1:0] granted_c;

	logic                            m_valid_q;
	logic [idpa_pkg::OUT_DATA_W-1:0] m_data_q;

	// candidate bits
	always_comb begin
		for (int i = 0; i < PADN; i++) begin
			if (i < NUM_IDS) begin
				fr_vec[i] = !in_use_q[i] && (32'(i) < {21'd0, max_ids_q});
				pd_vec[i] = del_q[i] && (32'(i) < {21'd0, max_ids_q});
				eq_vec[i] = del_q[i] == ((i != 0) && in_use_q[i]);
			end else begin
				fr_vec[i] = 1'b0;
				pd_vec[i] = 1'b0;
				eq_vec[i] = 1'b1;
			end
		end
	end

	// first level: priority encode within each group
	always_comb begin
		for (int g = 0; g < NG; g++) begin
			fr_any_c[g] = |fr_vec[g*G +: G];
			pd_any_c[g] = |pd_vec[g*G +: G];
			ok_c[g]     = &eq_vec[g*G +: G];
			fr_idx_c[g] = '0;
			pd_idx_c[g] = '0;
			for (int b = G - 1; b >= 0; b--) begin
				if (fr_vec[g*G + b]) begin
					fr_idx_c[g] = GIW'(b);
				end
				if (pd_vec[g*G + b]) begin
					pd_idx_c[g] = GIW'(b);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		fr_any_s1 <= fr_any_c;
		pd_any_s1 <= pd_any_c;
		ok_s1     <= ok_c;
		for (int g = 0; g < NG; g++) begin
			fr_idx_s1[g] <= fr_idx_c[g];
			pd_idx_s1[g] <= pd_idx_c[g];
		end
	end

	// second level: across groups
	always_comb begin
		fr_found_c = |fr_any_s1;
		pd_any_c2  = |pd_any_s1;
		all_c      = &ok_s1;
		fr_id_c    = '0;
		pd_id_c    = '0;
		for (int g = NG - 1; g >= 0; g--) begin
			if (fr_any_s1[g]) begin
				fr_id_c = IDXW'(g * G + int'(fr_idx_s1[g]));
			end
			if (pd_any_s1[g]) begin
				pd_id_c = IDXW'(g * G + int'(pd_idx_s1[g]));
			end
		end
	end

	always_ff @(posedge clk) begin
		fr_found_s2 <= fr_found_c;
		pd_any_s2   <= pd_any_c2;
		all_s2      <= all_c;
		fr_id_s2    <= fr_id_c;
		pd_id_s2    <= pd_id_c;
	end

	// state of the target id
	always_comb begin
		t_valid = 32'(target_q) < NUM_IDS;
		tidx    = IDXW'(target_q);
		t_use   = in_use_q[tidx];
		t_del   = del_q[tidx];
		t_pend  = (max_ids_q != '0) && t_use && t_del;
		t_live  = (tidx == '0) || t_use;
		if (!t_valid) begin
			id_st_c = idpa_pkg::ID_INVALID;
		end else if (t_pend) begin
			id_st_c = idpa_pkg::ID_DELETING;
		end else if (t_live) begin
			id_st_c = idpa_pkg::ID_IN_USE;
		end else begin
			id_st_c = idpa_pkg::ID_UNUSED;
		end
	end

	always_comb begin
		create_ok = (count_q <= max_ids_q) && fr_found_s2;
		granted_c = '0;
		case (mode_q)
			idpa_pkg::MODE_CREATE: begin
				status_c = create_ok ? idpa_pkg::STS_OK : idpa_pkg::STS_FULL;
				if (create_ok) begin
					granted_c = idpa_pkg::ID_OUT_W'(fr_id_s2);
				end
			end
			idpa_pkg::MODE_DEL_ONE: begin
				status_c = (id_st_c inside {idpa_pkg::ID_IN_USE, idpa_pkg::ID_DELETING}) ?
					idpa_pkg::STS_OK : idpa_pkg::STS_INVALID;
			end
			idpa_pkg::MODE_DEL_ALL: status_c = idpa_pkg::STS_OK;
			idpa_pkg::MODE_QUERY,
			idpa_pkg::MODE_FINISH: begin
				status_c = t_valid ? idpa_pkg::STS_OK : idpa_pkg::STS_INVALID;
			end
			default: status_c = idpa_pkg::STS_INVALID;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			mode_q   <= mode_in;
			target_q <= target_in;
		end
		if (cmd.apply) begin
			status_q  <= status_c;
			granted_q <= granted_c;
		end
	end

	// bitmaps, count and limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q  <= NUM_IDS'(1);
			del_q     <= '0;
			count_q   <= '0;
			max_ids_q <= idpa_pkg::MAX_IDS_RST;
		end else begin
			if (cfg_we) begin
				max_ids_q <= cfg_data;
			end
			if (cmd.apply) begin
				case (mode_q)
					idpa_pkg::MODE_CREATE: begin
						if (create_ok) begin
							in_use_q[fr_id_s2] <= 1'b1;
							if (count_q != idpa_pkg::COUNT_MAX) begin
								count_q <= count_q + 1'b1;
							end
						end
					end
					idpa_pkg::MODE_DEL_ONE: begin
						if (status_c == idpa_pkg::STS_OK && t_use) begin
							del_q[tidx] <= 1'b1;
						end
					end
					idpa_pkg::MODE_DEL_ALL: begin
						for (int i = 1; i < NUM_IDS; i++) begin
							if ((i == 1 || 32'(i) < {21'd0, max_ids_q}) && in_use_q[i]) begin
								del_q[i] <= 1'b1;
							end
						end
					end
					idpa_pkg::MODE_FINISH: begin
						if (t_valid) begin
							in_use_q[tidx] <= 1'b0;
							del_q[tidx]    <= 1'b0;
							if (count_q != '0) begin
								count_q <= count_q - 1'b1;
							end
						end
					end
					default: begin
					end
				endcase
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			m_data_q <= {3'b000, count_q, all_s2, idpa_pkg::ID_OUT_W'(pd_id_s2), pd_any_s2,
				id_st_c, granted_q, status_q};
		end
	end

	assign m_tvalid     = m_valid_q;
	assign m_tdata      = m_data_q;
	assign sts.out_busy = m_valid_q && !m_tready;

`ifndef NO_ASSERTIONS
	a_del_subset: assert property (@(posedge clk) disable iff (!arst_n)
		(del_q & ~in_use_q) == '0)
		else $error("pending id not in use");

	a_count_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.apply |=> $stable(count_q))
		else $error("live count changed outside a command");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !(m_valid_q && !m_tready))
		else $error("result overwritten before it was taken");

	a_grant_set: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.apply && mode_q == idpa_pkg::MODE_CREATE && create_ok) |=>
		in_use_q[$past(fr_id_s2)])
		else $error("granted id not marked in use");
`endif

endmodule

FILE: test/tb.sv
module tb;

	localparam int NUM_IDS = 1024;
	localparam int QUIET_LIMIT = 1000;
	localparam logic [idpa_pkg::MODE_W-1:0] MODE_RSVD5 = 3'd5;
	localparam logic [idpa_pkg::MODE_W-1:0] MODE_RSVD6 = 3'd6;
	localparam logic [idpa_pkg::MODE_W-1:0] MODE_RSVD7 = 3'd7;

	// fields from the highest bit down, as on m_axis_tdata
	typedef struct packed {
		logic [10:0] live;
		logic        all_marked;
		logic [9:0]  first;
		logic        any;
		logic [1:0]  state;
		logic [9:0]  granted;
		logic [1:0]  status;
	} resp_t;

	typedef struct {
		logic [2:0]  mode;
		logic [10:0] tgt;
		bit          known;
		resp_t       want;
	} dir_row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic [2:0]  s_axis_tuser = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [39:0] m_axis_tdata;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [10:0] cfg_data = '0;

	// typed expectation travelling with the directed word
	bit          row_known = 1'b0;
	resp_t       row_want = '0;

	logic [NUM_IDS-1:0] used_map;
	logic [NUM_IDS-1:0] marked_map;
	logic [10:0] live_cnt;
	logic [10:0] max_ids_q;
	resp_t       due_results[$];
	int          errs = 0;
	int          quiet = 0;
	int          rx_hold = 0;
	bit          idling = 1'b1;
	resp_t       seen_w, want_w;
	bit          hs;

	id_pool_allocator_with_deferred_delete #(
		.NUM_IDS(NUM_IDS)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic resp_t mk(input logic [1:0] st, input logic [9:0] gr,
			input logic [1:0] ids, input logic an, input logic [9:0] fp,
			input logic al, input logic [10:0] lc);
		resp_t r;
		r = {lc, al, fp, an, ids, gr, st};
		return r;
	endfunction

	function automatic string show(input resp_t r);
		return $sformatf("sts %0d id %0d state %0d any %0d first %0d all %0d live %0d",
			r.status, r.granted, r.state, r.any, r.first, r.all_marked, r.live);
	endfunction

	function automatic logic [1:0] id_view(input logic [10:0] tg);
		logic pend, held;
		if (tg >= NUM_IDS)
			return idpa_pkg::ID_INVALID;
		pend = (max_ids_q != 0) && used_map[tg[9:0]] && marked_map[tg[9:0]];
		held = (tg == 0) || used_map[tg[9:0]];
		if (held && !pend)
			return idpa_pkg::ID_IN_USE;
		if (pend)
			return idpa_pkg::ID_DELETING;
		return idpa_pkg::ID_UNUSED;
	endfunction

	function automatic resp_t pool_step(input logic [2:0] md, input logic [10:0] tg);
		resp_t r;
		int eff, i;
		bit found;
		logic [1:0] s;
		r = '0;
		found = 1'b0;
		eff = (max_ids_q < NUM_IDS) ? max_ids_q : NUM_IDS;
		case (md)
			idpa_pkg::MODE_CREATE: begin
				if (live_cnt <= max_ids_q)
					for (i = 0; i < eff && !found; i++)
						if (!used_map[i]) begin
							found = 1'b1;
							r.granted = 10'(i);
						end
				if (found) begin
					used_map[r.granted] = 1'b1;
					if (live_cnt != idpa_pkg::COUNT_MAX)
						live_cnt++;
				end else begin
					r.status = idpa_pkg::STS_FULL;
				end
			end
			idpa_pkg::MODE_DEL_ONE: begin
				s = id_view(tg);
				if (s == idpa_pkg::ID_INVALID || s == idpa_pkg::ID_UNUSED)
					r.status = idpa_pkg::STS_INVALID;
				else if (s == idpa_pkg::ID_IN_USE && used_map[tg[9:0]])
					marked_map[tg[9:0]] = 1'b1;
			end
			idpa_pkg::MODE_DEL_ALL: begin
				for (i = 1; i < NUM_IDS; i++)
					if ((i == 1 || i < max_ids_q) && used_map[i])
						marked_map[i] = 1'b1;
			end
			idpa_pkg::MODE_QUERY: begin
				if (tg >= NUM_IDS)
					r.status = idpa_pkg::STS_INVALID;
			end
			idpa_pkg::MODE_FINISH: begin
				if (tg >= NUM_IDS) begin
					r.status = idpa_pkg::STS_INVALID;
				end else begin
					used_map[tg[9:0]] = 1'b0;
					marked_map[tg[9:0]] = 1'b0;
					if (live_cnt != 0)
						live_cnt--;
				end
			end
			default: begin
				r.status = idpa_pkg::STS_INVALID;
			end
		endcase
		found = 1'b0;
		for (i = 0; i < eff && !found; i++)
			if (marked_map[i]) begin
				found = 1'b1;
				r.first = 10'(i);
			end
		r.any = found;
		r.all_marked = (marked_map == (used_map & ~{{(NUM_IDS-1){1'b0}}, 1'b1}));
		r.state = id_view(tg);
		r.live = live_cnt;
		return r;
	endfunction

	function automatic logic [10:0] pick_tgt();
		int r;
		r = $urandom_range(0, 99);
		if (r < 75)
			return 11'($urandom_range(0, 63));
		if (r < 90)
			return 11'($urandom_range(0, NUM_IDS - 1));
		return 11'($urandom_range(NUM_IDS, 2047));
	endfunction

	// result side stalls in bursts
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold <= rx_hold - 1;
			m_axis_tready <= 1'b0;
		end else if (idling && $urandom_range(0, 5) == 0) begin
			rx_hold <= $urandom_range(0, 4);
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			hs = 1'b0;
			if (m_axis_tvalid && m_axis_tready) begin
				hs = 1'b1;
				seen_w = m_axis_tdata[36:0];
				if (due_results.size() == 0) begin
					if (errs < 10)
						$display("unexpected result word: %s", show(seen_w));
					errs++;
				end else begin
					want_w = due_results.pop_front();
					if (m_axis_tdata !== {3'b000, want_w}) begin
						if (errs < 10)
							$display("result mismatch\n  want %s\n  got  %s (pad %b)",
								show(want_w), show(seen_w), m_axis_tdata[39:37]);
						errs++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				hs = 1'b1;
				want_w = pool_step(s_axis_tuser, s_axis_tdata[10:0]);
				due_results.push_back(row_known ? row_want : want_w);
			end
			if (cfg_valid && cfg_ready) begin
				hs = 1'b1;
				max_ids_q = cfg_data;
			end
			quiet = hs ? 0 : quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	task automatic send_cmd(input logic [2:0] md, input logic [10:0] tg, input bit known,
			input resp_t want);
		if (idling && $urandom_range(0, 6) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {5'b00000, tg};
		s_axis_tuser <= md;
		row_known <= known;
		row_want <= want;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic write_limit(input logic [10:0] v);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	initial begin
		dir_row_t dir_rows [25];
		logic [10:0] limits [8];
		logic [2:0] md;
		logic [10:0] tg;
		int ph, k, r, j;

		used_map = '0;
		used_map[0] = 1'b1;
		marked_map = '0;
		live_cnt = '0;
		max_ids_q = idpa_pkg::MAX_IDS_RST;

		dir_rows = '{
			'{idpa_pkg::MODE_QUERY, 11'd0, 1'b1,
				mk(idpa_pkg::STS_OK, 10'd0, idpa_pkg::ID_IN_USE, 1'b0, 10'd0, 1'b1, 11'd0)},
			'{idpa_pkg::MODE_QUERY, 11'd2047, 1'b1,
				mk(idpa_pkg::STS_INVALID, 10'd0, idpa_pkg::ID_INVALID, 1'b0, 10'd0, 1'b1,
					11'd0)},
			'{idpa_pkg::MODE_QUERY, 11'd1024, 1'b1,
				mk(idpa_pkg::STS_INVALID, 10'd0, idpa_pkg::ID_INVALID, 1'b0, 10'd0, 1'b1,
					11'd0)},
			'{idpa_pkg::MODE_FINISH, 11'd2047, 1'b1,
				mk(idpa_pkg::STS_INVALID, 10'd0, idpa_pkg::ID_INVALID, 1'b0, 10'd0, 1'b1,
					11'd0)},
			'{idpa_pkg::MODE_DEL_ONE, 11'd1023, 1'b1,
				mk(idpa_pkg::STS_INVALID, 10'd0, idpa_pkg::ID_UNUSED, 1'b0, 10'd0, 1'b1,
					11'd0)},
			'{MODE_RSVD5, 11'd0, 1'b1,
				mk(idpa_pkg::STS_INVALID, 10'd0, idpa_pkg::ID_IN_USE, 1'b0, 10'd0, 1'b1,
					11'd0)},
			'{MODE_RSVD6, 11'd2047, 1'b1,
				mk(idpa_pkg::STS_INVALID, 10'd0, idpa_pkg::ID_INVALID, 1'b0, 10'd0, 1'b1,
					11'd0)},
			'{MODE_RSVD7, 11'd1, 1'b1,
				mk(idpa_pkg::STS_INVALID, 10'd0, idpa_pkg::ID_UNUSED, 1'b0, 10'd0, 1'b1,
					11'd0)},
			'{idpa_pkg::MODE_CREATE, 11'd0, 1'b1,
				mk(idpa_pkg::STS_OK, 10'd1, idpa_pkg::ID_IN_USE, 1'b0, 10'd0, 1'b0, 11'd1)},
			'{idpa_pkg::MODE_CREATE, 11'd2, 1'b0, '0},
			'{idpa_pkg::MODE_CREATE, 11'd3, 1'b0, '0},
			'{idpa_pkg::MODE_DEL_ONE, 11'd1, 1'b0, '0},
			'{idpa_pkg::MODE_DEL_ONE, 11'd1, 1'b0, '0},
			'{idpa_pkg::MODE_DEL_ALL, 11'd2, 1'b0, '0},
			'{idpa_pkg::MODE_QUERY, 11'd3, 1'b0, '0},
			'{idpa_pkg::MODE_FINISH, 11'd1, 1'b0, '0},
			'{idpa_pkg::MODE_FINISH, 11'd1, 1'b0, '0},
			'{idpa_pkg::MODE_FINISH, 11'd1023, 1'b0, '0},
			'{idpa_pkg::MODE_FINISH, 11'd2, 1'b0, '0},
			'{idpa_pkg::MODE_FINISH, 11'd3, 1'b0, '0},
			'{idpa_pkg::MODE_DEL_ONE, 11'd0, 1'b0, '0},
			'{idpa_pkg::MODE_DEL_ALL, 11'd0, 1'b0, '0},
			'{idpa_pkg::MODE_FINISH, 11'd0, 1'b0, '0},
			'{idpa_pkg::MODE_CREATE, 11'd0, 1'b0, '0},
			'{idpa_pkg::MODE_QUERY, 11'd0, 1'b0, '0}
		};
		limits = '{11'd1024, 11'd40, 11'd5, 11'd0, 11'd1, 11'd2, 11'd0, 11'd1024};
		limits[6] = 11'($urandom_range(0, 1024));

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_cmd(dir_rows[i].mode, dir_rows[i].tgt, dir_rows[i].known, dir_rows[i].want);

		for (ph = 0; ph < 8; ph++) begin
			drain();
			write_limit(limits[ph]);
			idling = (ph != 7);
			for (k = 0; k < 230; k++) begin
				// one pause mid-phase until the pipeline is empty
				if (ph == 1 && k == 120)
					drain();
				r = $urandom_range(0, 99);
				tg = pick_tgt();
				if (r < 35) begin
					md = idpa_pkg::MODE_CREATE;
				end else if (r < 50) begin
					md = idpa_pkg::MODE_DEL_ONE;
				end else if (r < 55) begin
					md = idpa_pkg::MODE_DEL_ALL;
				end else if (r < 70) begin
					md = idpa_pkg::MODE_QUERY;
				end else if (r < 95) begin
					md = idpa_pkg::MODE_FINISH;
					// finish the lowest marked id half of the time
					if ($urandom_range(0, 1))
						for (j = NUM_IDS - 1; j >= 0; j--)
							if (marked_map[j])
								tg = 11'(j);
				end else begin
					case ($urandom_range(0, 2))
						0: md = MODE_RSVD5;
						1: md = MODE_RSVD6;
						default: md = MODE_RSVD7;
					endcase
				end
				send_cmd(md, tg, 1'b0, '0);
			end
		end

		s_axis_tvalid <= 1'b0;
		while (due_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		errs += due_results.size();
		if (errs == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
